// ===== sv/lav_pkg.sv =====
// Shared constants, command and queue status types for the victim select block.
package lav_pkg;

    localparam int WAYS    = 8;
    localparam int SETS    = 64;

    localparam int OpW     = 2;
    localparam int SetW    = 6;
    localparam int WayW    = 3;
    localparam int CostW   = 3;
    localparam int LambdaW = 4;
    localparam int StampW  = 32;

    localparam int WayAw   = $clog2(WAYS);
    localparam int SetAw   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ScoreW  = LambdaW + CostW + 1;

    localparam int QDepth  = 2;
    localparam int QAw     = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCw     = $clog2(QDepth + 1);

    localparam logic [LambdaW-1:0] LambdaReset = 4'd4;
    localparam logic [StampW-1:0]  ClockReset  = 32'd1;

    localparam logic [OpW-1:0] OpAccess = 2'd0;
    localparam logic [OpW-1:0] OpFill   = 2'd1;
    localparam logic [OpW-1:0] OpInval  = 2'd2;
    localparam logic [OpW-1:0] OpQuery  = 2'd3;

    typedef struct packed {
        logic [OpW-1:0]    op;
        logic [SetAw-1:0]  set_addr;
        logic [WayAw-1:0]  way_idx;
        logic [CostW-1:0]  cost;
        logic [StampW-1:0] stamp;
        logic              set_ok;
        logic              way_ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== sv/lav_front.sv =====
// Front end: input transfer, access clock and command classification.
module lav_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [lav_pkg::OpW-1:0]  s_operation,
    input  logic [lav_pkg::SetW-1:0] s_set_index,
    input  logic [lav_pkg::WayW-1:0] s_way,
    input  logic [lav_pkg::CostW-1:0] s_miss_cost,
    input  lav_pkg::q_status_t       q_status,
    output logic                     push,
    output lav_pkg::cmd_t            push_cmd
);

    logic [lav_pkg::StampW-1:0] clock_reg, clock_next;
    logic                       accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept;

    always_comb begin
        clock_next = clock_reg;
        if (accept && (clock_reg != '1)) begin
            clock_next = clock_reg + lav_pkg::StampW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= lav_pkg::ClockReset;
        end else begin
            clock_reg <= clock_next;
        end
    end

    always_comb begin
        push_cmd.op       = s_operation;
        push_cmd.set_addr = lav_pkg::SetAw'(s_set_index);
        push_cmd.way_idx  = lav_pkg::WayAw'(s_way);
        push_cmd.cost     = s_miss_cost;
        push_cmd.stamp    = clock_reg;
        push_cmd.set_ok   = 32'(s_set_index) < 32'(lav_pkg::SETS);
        push_cmd.way_ok   = 32'(s_way) < 32'(lav_pkg::WAYS);
    end

endmodule

// ===== sv/lav_fifo.sv =====
// Command queue between the front end and the back end.
module lav_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lav_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output lav_pkg::cmd_t      pop_cmd,
    output lav_pkg::q_status_t q_status
);

    lav_pkg::cmd_t                entry_reg [lav_pkg::QDepth];
    logic [lav_pkg::QAw-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lav_pkg::QAw-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lav_pkg::QCw-1:0]      count_reg, count_next;

    function automatic logic [lav_pkg::QAw-1:0] ptr_inc(input logic [lav_pkg::QAw-1:0] p);
        return (p == lav_pkg::QAw'(lav_pkg::QDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == lav_pkg::QCw'(lav_pkg::QDepth));
    assign q_status.empty = (count_reg == '0);

endmodule

// ===== sv/lav_back.sv =====
// Back end: stamp and cost memories, rank sequencer, scoring and result register.
module lav_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lav_pkg::LambdaW-1:0] cfg_wr_data,
    input  lav_pkg::q_status_t          q_status,
    output logic                        pop,
    input  lav_pkg::cmd_t               pop_cmd,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lav_pkg::WayW-1:0]    m_victim_way
);

    localparam int Ways   = lav_pkg::WAYS;
    localparam int WayAw  = lav_pkg::WayAw;
    localparam int StampW = lav_pkg::StampW;
    localparam int CostW  = lav_pkg::CostW;
    localparam int ScoreW = lav_pkg::ScoreW;

    localparam logic [1:0] StIdle    = 2'd0;
    localparam logic [1:0] StCompare = 2'd1;
    localparam logic [1:0] StRank    = 2'd2;
    localparam logic [1:0] StScore   = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [lav_pkg::LambdaW-1:0] lambda_reg, lambda_next;
    logic [lav_pkg::SETS-1:0]    row_valid_reg, row_valid_next;
    logic                        query_bad_reg, query_bad_next;
    logic [WayAw-1:0]            step_reg, step_next;
    logic [WayAw-1:0]            ref_reg, ref_next;
    logic                        m_valid_reg, m_valid_next;
    logic [lav_pkg::WayW-1:0]    m_victim_way_reg;

    logic                        do_write, rd_en, row_ok, out_load;
    logic [StampW-1:0]           new_stamp;
    logic [Ways-1:0]             stamp_en, cost_en;
    logic [StampW-1:0]           wr_stamp [Ways];
    logic [CostW-1:0]            wr_cost [Ways];
    logic [StampW-1:0]           rd_stamp [Ways];
    logic [CostW-1:0]            rd_cost [Ways];
    logic                        rd_row_valid_reg;

    logic [StampW-1:0]           eff_stamp [Ways];
    logic [Ways-1:0]             lt_reg [Ways];
    logic [Ways-1:0]             lt_next [Ways];
    logic [CostW-1:0]            cost_reg [Ways];
    logic [WayAw-1:0]            rank_reg [Ways];
    logic [Ways-1:0]             col [Ways];
    logic [Ways-1:0]             cand;
    logic [WayAw-1:0]            first_min, pick;
    logic [ScoreW-1:0]           score [Ways];
    logic [WayAw-1:0]            best;

    assign pop      = (state_reg == StIdle) && !q_status.empty;
    assign do_write = pop && (pop_cmd.op != lav_pkg::OpQuery) && pop_cmd.set_ok && pop_cmd.way_ok;
    assign rd_en    = pop && (pop_cmd.op == lav_pkg::OpQuery) && pop_cmd.set_ok;
    assign row_ok   = row_valid_reg[pop_cmd.set_addr];
    assign new_stamp = (pop_cmd.op == lav_pkg::OpInval) ? '0 : pop_cmd.stamp;

    // An untouched row is written whole so that the other ways read as zero.
    always_comb begin
        for (int w = 0; w < Ways; w++) begin
            logic hit;
            logic fill_hit;
            hit         = (pop_cmd.way_idx == WayAw'(w));
            fill_hit    = hit && (pop_cmd.op == lav_pkg::OpFill);
            stamp_en[w] = do_write && (hit || !row_ok);
            wr_stamp[w] = hit ? new_stamp : '0;
            cost_en[w]  = do_write && (fill_hit || !row_ok);
            wr_cost[w]  = fill_hit ? pop_cmd.cost : '0;
        end
    end

    for (genvar gw = 0; gw < Ways; gw++) begin : g_way
        logic [StampW-1:0] stamp_mem [lav_pkg::SETS];
        logic [CostW-1:0]  cost_mem [lav_pkg::SETS];
        logic [StampW-1:0] rd_stamp_reg;
        logic [CostW-1:0]  rd_cost_reg;

        always_ff @(posedge aclk) begin
            if (stamp_en[gw]) begin
                stamp_mem[pop_cmd.set_addr] <= wr_stamp[gw];
            end
            if (cost_en[gw]) begin
                cost_mem[pop_cmd.set_addr] <= wr_cost[gw];
            end
            if (rd_en) begin
                rd_stamp_reg <= stamp_mem[pop_cmd.set_addr];
                rd_cost_reg  <= cost_mem[pop_cmd.set_addr];
            end
        end

        assign rd_stamp[gw] = rd_stamp_reg;
        assign rd_cost[gw]  = rd_cost_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_valid_reg <= row_ok;
        end
    end

    always_comb begin
        for (int v = 0; v < Ways; v++) begin
            eff_stamp[v] = rd_row_valid_reg ? rd_stamp[v] : '0;
        end
        for (int v = 0; v < Ways; v++) begin
            for (int w = 0; w < Ways; w++) begin
                lt_next[v][w] = eff_stamp[v] < eff_stamp[w];
            end
        end
    end

    always_comb begin
        for (int w = 0; w < Ways; w++) begin
            for (int v = 0; v < Ways; v++) begin
                col[w][v] = lt_reg[v][w];
            end
        end
        cand      = lt_reg[ref_reg];
        first_min = '0;
        pick      = '0;
        for (int w = Ways - 1; w >= 0; w--) begin
            if (col[w] == '0) begin
                first_min = WayAw'(w);
            end
            if (cand[w] && ((cand & col[w]) == '0)) begin
                pick = WayAw'(w);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < Ways; w++) begin
            score[w] = ScoreW'(rank_reg[w]) + ScoreW'(lambda_reg) * ScoreW'(cost_reg[w]);
        end
        best = '0;
        for (int w = 1; w < Ways; w++) begin
            if (score[w] < score[best]) begin
                best = WayAw'(w);
            end
        end
    end

    assign out_load = (state_reg == StScore) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        query_bad_next = query_bad_reg;
        step_next      = step_reg;
        ref_next       = ref_reg;
        row_valid_next = row_valid_reg;
        lambda_next    = cfg_wr_en ? cfg_wr_data : lambda_reg;
        if (do_write) begin
            row_valid_next[pop_cmd.set_addr] = 1'b1;
        end
        case (state_reg)
            StIdle: begin
                if (pop && (pop_cmd.op == lav_pkg::OpQuery)) begin
                    query_bad_next = !pop_cmd.set_ok;
                    state_next     = pop_cmd.set_ok ? StCompare : StScore;
                end
            end
            StCompare: begin
                step_next  = '0;
                state_next = StRank;
            end
            StRank: begin
                ref_next  = (step_reg == '0) ? first_min : pick;
                step_next = step_reg + 1'b1;
                if (step_reg == WayAw'(Ways - 1)) begin
                    state_next = StScore;
                end
            end
            StScore: begin
                if (out_load) begin
                    query_bad_next = 1'b0;
                    state_next     = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == StCompare) begin
            lt_reg <= lt_next;
            for (int w = 0; w < Ways; w++) begin
                cost_reg[w] <= rd_row_valid_reg ? rd_cost[w] : '0;
            end
        end
        if (state_reg == StRank) begin
            if (step_reg == '0) begin
                for (int w = 0; w < Ways; w++) begin
                    rank_reg[w] <= '0;
                end
            end else begin
                rank_reg[pick] <= step_reg;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_victim_way_reg <= query_bad_reg ? '0 : lav_pkg::WayW'(best);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= StIdle;
            lambda_reg    <= lav_pkg::LambdaReset;
            row_valid_reg <= '0;
            query_bad_reg <= 1'b0;
            step_reg      <= '0;
            ref_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lambda_reg    <= lambda_next;
            row_valid_reg <= row_valid_next;
            query_bad_reg <= query_bad_next;
            step_reg      <= step_next;
            ref_reg       <= ref_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_victim_way = m_victim_way_reg;

endmodule

// ===== sv/mlp_aware_lin_victim_select.sv =====
// Top level: cost-weighted LIN victim select with a decoupled front and back end.
// Input takes one item per cycle while the two-entry command queue has room.
// Access, fill and invalidate leave the queue at one per cycle (one memory write)
// while no victim query is in the back end. A victim query runs a row read, compare
// matrix, one successive-minimum ranking step per way, then weighted scoring.
// Reset clears the row valid bits, so every stamp and cost reads as zero at once;
// the access clock resets to one and lambda to four. No clearing pass is needed.
module mlp_aware_lin_victim_select (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lav_pkg::LambdaW-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lav_pkg::OpW-1:0]      s_operation,
    input  logic [lav_pkg::SetW-1:0]     s_set_index,
    input  logic [lav_pkg::WayW-1:0]     s_way,
    input  logic [lav_pkg::CostW-1:0]    s_miss_cost,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lav_pkg::WayW-1:0]     m_victim_way
);

    lav_pkg::q_status_t q_status;
    lav_pkg::cmd_t      push_cmd;
    lav_pkg::cmd_t      pop_cmd;
    logic               push;
    logic               pop;

    lav_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_set_index (s_set_index),
        .s_way       (s_way),
        .s_miss_cost (s_miss_cost),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    lav_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    lav_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_status     (q_status),
        .pop          (pop),
        .pop_cmd      (pop_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_victim_way (m_victim_way)
    );

endmodule

// ===== sv/lav_checker.sv =====
// Port-level checks for the victim select top level, attached by bind.
module lav_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [lav_pkg::WayW-1:0] m_victim_way
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_victim_way))
        else $error("result changed or dropped while stalled");

    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_way_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_victim_way) < 32'(lav_pkg::WAYS)))
        else $error("victim way out of range");

endmodule

bind mlp_aware_lin_victim_select lav_checker u_lav_checker (.*);
